### src/rsp_pkg.sv
package rsp_pkg;

    // Field widths and fixed codes
    localparam int DATA_W = 8;
    localparam int CFG_W  = 6;
    // Wide enough for any parity length up to 64
    localparam int LEN_W  = 7;

    localparam logic [CFG_W-1:0]  RESET_LEN  = 6'd10;
    // Low byte of the field polynomial x^8+x^4+x^3+x^2+1
    localparam logic [DATA_W-1:0] POLY_LOW   = 8'h1D;

    typedef logic [DATA_W-1:0] byte_t;

    // Generator derivation sequencer
    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_INIT,
        GEN_RUN
    } gen_state_t;

    // Generator status toward the datapath
    typedef struct packed {
        logic             ready;
        logic [LEN_W-1:0] eff_len;
    } gen_status_t;

    // Parity buffer load request
    typedef struct packed {
        logic             load;
        logic [LEN_W-1:0] count;
    } par_load_t;

    // Multiply by x in GF(256)
    function automatic byte_t gf_xtime(input byte_t a);
        byte_t r;
        r = {a[DATA_W-2:0], 1'b0};
        if (a[DATA_W-1])
        begin
            r = r ^ POLY_LOW;
        end
        return r;
    endfunction

    // GF(256) product, top bit of b first
    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t acc;
        acc = '0;
        for (int k = DATA_W - 1; k >= 0; k--)
        begin
            acc = gf_xtime(acc);
            if (b[k])
            begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

endpackage

### src/reed_solomon_parity_gf256_unit.sv
// Channel   Dir  Width  Contents
// s_*       in   8+1    tdata: data_byte[7:0]; tlast: last_byte
// m_*       out  8+1    tdata: parity_byte[7:0]; tlast: parity_last
// cfg_*     in   6      cfg_data: parity_length[5:0]
//
// One data word per cycle while s_tready is high; the remainder taps all update together.
// A last word loads the parity shift line; its n words leave one per cycle while m_tready is high.
// After reset or a config write the generator is derived in GEN_INIT and then
// GEN_RUN, one root factor per step, with s_tready low meanwhile.
// A last word stalls until the final parity word of the previous block leaves.
module reed_solomon_parity_gf256_unit #(
    parameter int MAX_PARITY = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rsp_pkg::DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rsp_pkg::DATA_W-1:0]   m_tdata,   // [7:0] parity_byte
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rsp_pkg::CFG_W-1:0]    cfg_data
);
    import rsp_pkg::*;

    logic [MAX_PARITY-1:0][DATA_W-1:0] coeffs, rem_step;
    gen_status_t                       status;
    par_load_t                         load;
    logic                              out_free;
    logic                              accept;
    logic                              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = status.ready && (!s_tlast || out_free);
    assign accept    = s_tvalid && s_tready;

    // Generator coefficients
    rsp_gen #(.MAX_PARITY(MAX_PARITY)) u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .coeffs    (coeffs),
        .status    (status)
    );

    // Remainder division
    rsp_lfsr #(.MAX_PARITY(MAX_PARITY)) u_lfsr (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_write),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .coeffs    (coeffs),
        .status    (status),
        .rem_step  (rem_step),
        .load      (load)
    );

    // Parity output
    rsp_outbuf #(.MAX_PARITY(MAX_PARITY)) u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (rem_step),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .free      (out_free)
    );

endmodule

### src/rsp_gen.sv
module rsp_gen #(
    parameter int MAX_PARITY = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [rsp_pkg::CFG_W-1:0]              cfg_data,
    output logic [MAX_PARITY-1:0][rsp_pkg::DATA_W-1:0] coeffs,
    output rsp_pkg::gen_status_t                   status
);
    import rsp_pkg::*;

    gen_state_t                      state_reg, state_next;
    logic [CFG_W-1:0]                len_reg;
    logic [LEN_W-1:0]                iter_reg, iter_next;
    logic [LEN_W-1:0]                eff_len;
    byte_t                           root_reg;
    logic [MAX_PARITY-1:0][DATA_W-1:0] coef_reg, coef_up, coef_step, coef_init;

    // Clamp the written length into 1..MAX_PARITY
    always_comb
    begin
        if (len_reg == '0)
            eff_len = LEN_W'(1);
        else if ({1'b0, len_reg} > LEN_W'(MAX_PARITY))
            eff_len = LEN_W'(MAX_PARITY);
        else
            eff_len = {1'b0, len_reg};
    end

    // One root factor (x - root) per step, all coefficients at once
    assign coef_up = coef_reg >> DATA_W;
    always_comb
    begin
        for (int j = 0; j < MAX_PARITY; j++)
        begin
            coef_step[j] = gf_mul(coef_reg[j], root_reg);
            if (LEN_W'(j + 1) < eff_len)
            begin
                coef_step[j] = coef_step[j] ^ coef_up[j];
            end
            coef_init[j] = (LEN_W'(j + 1) == eff_len) ? byte_t'(1) : '0;
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GEN_INIT;
            len_reg   <= RESET_LEN;
            iter_reg  <= '0;
        end
        else
        begin
            iter_reg <= iter_next;
            if (cfg_write)
            begin
                len_reg   <= cfg_data;
                state_reg <= GEN_INIT;
            end
            else
            begin
                state_reg <= state_next;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            GEN_IDLE:
            begin
                iter_next = '0;
            end
            GEN_INIT:
            begin
                iter_next  = '0;
                state_next = GEN_RUN;
            end
            GEN_RUN:
            begin
                iter_next = iter_reg + LEN_W'(1);
                if (iter_reg == eff_len - LEN_W'(1))
                begin
                    state_next = GEN_IDLE;
                end
            end
            default:
            begin
                state_next = GEN_INIT;
            end
        endcase
    end

    // Coefficient and root registers
    always_ff @(posedge clk)
    begin
        if (state_reg == GEN_INIT)
        begin
            coef_reg <= coef_init;
            root_reg <= byte_t'(1);
        end
        else if (state_reg == GEN_RUN)
        begin
            coef_reg <= coef_step;
            root_reg <= gf_xtime(root_reg);
        end
    end

    assign coeffs         = coef_reg;
    assign status.ready   = (state_reg == GEN_IDLE);
    assign status.eff_len = eff_len;

endmodule

### src/rsp_lfsr.sv
module rsp_lfsr #(
    parameter int MAX_PARITY = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       clear,
    input  logic                                       accept,
    input  logic [rsp_pkg::DATA_W-1:0]                 data_byte,
    input  logic                                       last_byte,
    input  logic [MAX_PARITY-1:0][rsp_pkg::DATA_W-1:0] coeffs,
    input  rsp_pkg::gen_status_t                       status,
    output logic [MAX_PARITY-1:0][rsp_pkg::DATA_W-1:0] rem_step,
    output rsp_pkg::par_load_t                         load
);
    import rsp_pkg::*;

    logic [MAX_PARITY-1:0][DATA_W-1:0] rem_reg, rem_up;
    byte_t                             factor;

    // One division step for every tap in parallel
    assign factor = data_byte ^ rem_reg[0];
    assign rem_up = rem_reg >> DATA_W;

    always_comb
    begin
        for (int i = 0; i < MAX_PARITY; i++)
        begin
            rem_step[i] = gf_mul(coeffs[i], factor);
            if (LEN_W'(i + 1) < status.eff_len)
            begin
                rem_step[i] = rem_step[i] ^ rem_up[i];
            end
            if (LEN_W'(i) >= status.eff_len)
            begin
                rem_step[i] = '0;
            end
        end
    end

    // Remainder register, cleared after a last word and on config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (clear)
        begin
            rem_reg <= '0;
        end
        else if (accept)
        begin
            rem_reg <= last_byte ? '0 : rem_step;
        end
    end

    assign load.load  = accept && last_byte;
    assign load.count = status.eff_len;

endmodule

### src/rsp_outbuf.sv
module rsp_outbuf #(
    parameter int MAX_PARITY = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  rsp_pkg::par_load_t                         load,
    input  logic [MAX_PARITY-1:0][rsp_pkg::DATA_W-1:0] load_data,
    input  logic                                       m_tready,
    output logic                                       m_tvalid,
    output logic [rsp_pkg::DATA_W-1:0]                 m_tdata,
    output logic                                       m_tlast,
    output logic                                       free
);
    import rsp_pkg::*;

    logic [MAX_PARITY-1:0][DATA_W-1:0] pbuf_reg;
    logic [LEN_W-1:0]                  cnt_reg;
    logic                              pop;

    assign pop  = m_tvalid && m_tready;
    // Room for a new block once the last pending word leaves
    assign free = (cnt_reg == '0) || ((cnt_reg == LEN_W'(1)) && m_tready);

    // Pending word count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load.load)
            cnt_reg <= load.count;
        else if (pop)
            cnt_reg <= cnt_reg - LEN_W'(1);
    end

    // Parity shift line, head word at index 0
    always_ff @(posedge clk)
    begin
        if (load.load)
            pbuf_reg <= load_data;
        else if (pop)
            pbuf_reg <= pbuf_reg >> DATA_W;
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = pbuf_reg[0];
    assign m_tlast  = (cnt_reg == LEN_W'(1));

endmodule

### src/rsp_checker.sv
module rsp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tlast,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rsp_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("parity word changed while stalled");

    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tlast))
        else $error("parity last flag changed while stalled");

    // A config write starts a derivation that blocks input
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input taken during generator derivation");

    // A last word always yields parity next cycle
    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no parity after last data word");

endmodule

bind reed_solomon_parity_gf256_unit rsp_checker u_rsp_checker (.*);

### test/tb_reed_solomon_parity_gf256_unit.sv
module tb_reed_solomon_parity_gf256_unit;

    import rsp_pkg::*;

    localparam int   MAX_P       = 32;
    localparam int   WORDS_PHASE = 75;
    localparam int   LONG_HOLD   = 400;
    localparam int   DRAIN_WAIT  = 40;
    localparam int   IDLE_SETTLE = 8;
    localparam byte_t GEN_ROOT   = 8'h02;

    // Directed table row kinds
    typedef enum logic {
        ROW_WORD,
        ROW_LEN
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        byte_t     value;         // data byte, or parity length in [5:0]
        logic      last;
        logic      typed;         // 1: every parity word of the block equals typed_parity
        byte_t     typed_parity;
    } stim_row_t;

    typedef struct packed {
        byte_t parity;
        logic  last;
    } parity_word_t;

    localparam int N_ROWS = 26;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        // reset length 10, empty remainder
        '{ROW_WORD, 8'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h80, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h01, 1'b1, 1'b0, 8'h00},
        // zero length acts as one: g(x) = x + 1, parity = data
        '{ROW_LEN,  8'd0,  1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'hFF, 1'b1, 1'b1, 8'hFF},
        '{ROW_WORD, 8'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_WORD, 8'h5A, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'hA5, 1'b1, 1'b0, 8'h00},
        // all ones clamps to the maximum
        '{ROW_LEN,  8'd63, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h7F, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'hFE, 1'b1, 1'b0, 8'h00},
        // partial block dropped by a length write
        '{ROW_WORD, 8'h12, 1'b0, 1'b0, 8'h00},
        '{ROW_LEN,  8'd33, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'hC3, 1'b1, 1'b0, 8'h00},
        '{ROW_LEN,  8'd1,  1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'hAA, 1'b1, 1'b1, 8'hAA},
        '{ROW_LEN,  8'd2,  1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h55, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h55, 1'b1, 1'b0, 8'h00},
        '{ROW_LEN,  8'd10, 1'b0, 1'b0, 8'h00},
        '{ROW_WORD, 8'h33, 1'b1, 1'b0, 8'h00},
        '{ROW_WORD, 8'h00, 1'b1, 1'b1, 8'h00}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata   = '0;    // [7:0] data_byte
    logic                s_tlast   = 1'b0;  // last_byte
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [DATA_W-1:0]   m_tdata;           // [7:0] parity_byte
    logic                m_tlast;           // parity_last
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;    // [5:0] parity_length

    int                  tx_idle_pct     = 19;
    int                  rx_idle_pct     = 63;
    logic                long_stall_req  = 1'b0;
    logic                long_stall_done = 1'b0;
    int                  hold_cnt        = 0;
    int                  err_count       = 0;

    // Encoder mirror
    byte_t               rem_regs [MAX_P];
    byte_t               gen_coef [MAX_P];
    int                  eff_len;
    parity_word_t        expected_parity_q [$];

    reed_solomon_parity_gf256_unit #(
        .MAX_PARITY(MAX_P)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // GF(256) product, shift-and-add from the low bit of b
    function automatic byte_t gf256_mult(input byte_t a, input byte_t b);
        byte_t acc;
        byte_t x;
        acc = '0;
        x   = a;
        for (int k = 0; k < DATA_W; k++)
        begin
            if (b[k])
            begin
                acc ^= x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ POLY_LOW) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

    // New length: clamp, clear remainder, rebuild prod (x - 2^i)
    function automatic void set_parity_length(input logic [CFG_W-1:0] len);
        byte_t root;
        byte_t t;
        eff_len = (len == 0) ? 1 : ((len > MAX_P) ? MAX_P : int'(len));
        root    = 8'h01;
        for (int i = 0; i < MAX_P; i++)
        begin
            rem_regs[i] = '0;
            gen_coef[i] = '0;
        end
        gen_coef[eff_len-1] = 8'h01;
        for (int i = 0; i < eff_len; i++)
        begin
            for (int j = 0; j < eff_len; j++)
            begin
                t = gf256_mult(gen_coef[j], root);
                if (j + 1 < eff_len)
                begin
                    t ^= gen_coef[j+1];
                end
                gen_coef[j] = t;
            end
            root = gf256_mult(root, GEN_ROOT);
        end
    endfunction

    // One LFSR division step; a last word queues the whole remainder
    function automatic void rs_divide_step(input byte_t d, input logic last,
                                           input logic typed, input byte_t typed_parity);
        byte_t        factor;
        parity_word_t w;
        factor = d ^ rem_regs[0];
        for (int i = 0; i + 1 < eff_len; i++)
        begin
            rem_regs[i] = rem_regs[i+1];
        end
        rem_regs[eff_len-1] = '0;
        for (int i = 0; i < eff_len; i++)
        begin
            rem_regs[i] ^= gf256_mult(gen_coef[i], factor);
        end
        if (last)
        begin
            for (int i = 0; i < eff_len; i++)
            begin
                w.parity = typed ? typed_parity : rem_regs[i];
                w.last   = (i + 1 == eff_len);
                expected_parity_q.push_back(w);
                rem_regs[i] = '0;
            end
        end
    endfunction

    function automatic logic [CFG_W-1:0] random_length();
        case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd32;
            3: return 6'd63;
            4: return CFG_W'($urandom_range(33, 62));
            default: return CFG_W'($urandom_range(2, 31));
        endcase
    endfunction

    // Offer one data word, with random gaps ahead of it
    task automatic send_word(input byte_t d, input logic last,
                             input logic typed, input byte_t typed_parity);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        rs_divide_step(d, last, typed, typed_parity);
    endtask

    // Length write, only once all parity words are out and the unit settles
    task automatic write_length(input logic [CFG_W-1:0] len);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_parity_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        set_parity_length(len);
    endtask

    // Random blocks; now and then a partial block dropped by a length write
    task automatic run_random_phase(input int words);
        int    sent;
        int    blen;
        logic  broken;
        byte_t d;
        sent = 0;
        while (sent < words)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                write_length(random_length());
            end
            blen   = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            broken = ($urandom_range(0, 11) == 0);
            for (int k = 0; k < blen; k++)
            begin
                case ($urandom_range(0, 9))
                    0: d = 8'h00;
                    1: d = 8'hFF;
                    default: d = byte_t'($urandom_range(0, 255));
                endcase
                send_word(d, (k == blen - 1) && !broken, 1'b0, 8'h00);
                sent++;
            end
            if (broken)
            begin
                write_length(random_length());
            end
        end
    endtask

    // Parity sink: check accepted words, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_parity_q.size() == 0)
            begin
                $display("%0t: unexpected parity word: actual parity=%02h last=%0b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                if (m_tdata !== expected_parity_q[0].parity)
                begin
                    $display("%0t: parity mismatch: expected %02h, actual %02h",
                             $time, expected_parity_q[0].parity, m_tdata);
                    err_count++;
                end
                if (m_tlast !== expected_parity_q[0].last)
                begin
                    $display("%0t: parity_last mismatch: expected %0b, actual %0b",
                             $time, expected_parity_q[0].last, m_tlast);
                    err_count++;
                end
                void'(expected_parity_q.pop_front());
            end
        end
        if (long_stall_req && !long_stall_done)
        begin
            long_stall_done <= 1'b1;
            hold_cnt        <= LONG_HOLD;
            m_tready        <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Main sequence
    initial
    begin
        set_parity_length(RESET_LEN);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_LEN)
            begin
                write_length(DIRECTED[r].value[CFG_W-1:0]);
            end
            else
            begin
                send_word(DIRECTED[r].value, DIRECTED[r].last,
                          DIRECTED[r].typed, DIRECTED[r].typed_parity);
            end
        end

        // sender idles less than the sink
        run_random_phase(WORDS_PHASE);

        // sink idles less than the sender
        tx_idle_pct <= 63;
        rx_idle_pct <= 19;
        run_random_phase(WORDS_PHASE);

        // no idling; long sink hold-off first so the input backs up
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        write_length(6'd32);
        long_stall_req <= 1'b1;
        run_random_phase(WORDS_PHASE);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_parity_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
